// ===== rtl/core/pbin_pkg.sv =====
// Shared types, constants and the arctangent table of the polar max-height binner.
package pbin_pkg;

   // field widths
   localparam int COORD_W  = 20;
   localparam int HEIGHT_W = 21;
   localparam int RADIUS_W = 19;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int PHASE_W  = 32;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 2;

   // parameter defaults
   localparam int DEF_MAX_RINGS    = 32;
   localparam int DEF_MAX_SECTORS  = 64;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES     = 24;

   // operations
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_HEIGHT = 2'd3;

   // register reset values
   localparam logic [5:0]          RST_RING_COUNT    = 6'd20;
   localparam logic [6:0]          RST_SECTOR_COUNT  = 7'd60;
   localparam logic [RADIUS_W-1:0] RST_RADIUS_LIMIT  = 19'd20480;
   localparam logic [COORD_W-1:0]  RST_SENSOR_HEIGHT = 20'd0;

   localparam logic [RADIUS_W-1:0] MIN_RADIUS = 19'd256;
   // -1000 m in 1/256 m
   localparam logic signed [HEIGHT_W-1:0] LOW_LIMIT = -21'sd256000;
   localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [HEIGHT_W-1:0] height_type;

   typedef struct packed {
      logic done;
      logic skip;
   } unit_status_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [PHASE_W-1:0] atan_turns(input logic [4:0] i);
      logic [PHASE_W-1:0] a;
      unique case (i)
         5'd0:  a = 32'h2000_0000;
         5'd1:  a = 32'h12E4_051E;
         5'd2:  a = 32'h09FB_385B;
         5'd3:  a = 32'h0511_11D4;
         5'd4:  a = 32'h028B_0D43;
         5'd5:  a = 32'h0145_D7E1;
         5'd6:  a = 32'h00A2_F61E;
         5'd7:  a = 32'h0051_7C55;
         5'd8:  a = 32'h0028_BE53;
         5'd9:  a = 32'h0014_5F2F;
         5'd10: a = 32'h000A_2F98;
         5'd11: a = 32'h0005_17CC;
         5'd12: a = 32'h0002_8BE6;
         5'd13: a = 32'h0001_45F3;
         5'd14: a = 32'h0000_A2F9;
         5'd15: a = 32'h0000_517D;
         5'd16: a = 32'h0000_28BE;
         5'd17: a = 32'h0000_145F;
         5'd18: a = 32'h0000_0A30;
         5'd19: a = 32'h0000_0518;
         5'd20: a = 32'h0000_028C;
         5'd21: a = 32'h0000_0146;
         5'd22: a = 32'h0000_00A3;
         5'd23: a = 32'h0000_0051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/core/pbin_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pbin_ring.sv =====
// Range check and exact ring search on squared values.
module pbin_ring #(
   parameter int MAX_RINGS = 32,
   localparam int RING_W = $clog2(MAX_RINGS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  pbin_pkg::coord_type              point_x,
   input  pbin_pkg::coord_type              point_y,
   input  logic [pbin_pkg::RADIUS_W-1:0]    radius_limit,
   input  logic [RING_W-1:0]                rings_used,
   output pbin_pkg::unit_status_type        status,
   output logic [RING_W-1:0]                ring
);
   import pbin_pkg::*;

   localparam int R2_W  = 2 * RING_W;
   localparam int M2_W  = 2 * RADIUS_W;
   localparam int HALF  = SQ_W / 2;
   localparam int LHS_W = SQ_W + R2_W;

   localparam logic [3:0] RS_IDLE = 4'd0;
   localparam logic [3:0] RS_SQX  = 4'd1;
   localparam logic [3:0] RS_SQY  = 4'd2;
   localparam logic [3:0] RS_SQM  = 4'd3;
   localparam logic [3:0] RS_CHK  = 4'd4;
   localparam logic [3:0] RS_LO   = 4'd5;
   localparam logic [3:0] RS_HI   = 4'd6;
   localparam logic [3:0] RS_SRCH = 4'd7;
   localparam logic [3:0] RS_DONE = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic                  skip_ff, skip_in;
   coord_type             x_ff, x_in, y_ff, y_in;
   logic [SQ_W-1:0]       xx_ff, xx_in, yy_ff, yy_in, r2_ff, r2_in;
   logic [M2_W-1:0]       m2_ff, m2_in;
   logic [R2_W-1:0]       rr2_ff, rr2_in;
   logic [LHS_W-1:0]      lo_ff, lo_in, lhs_ff, lhs_in, acc_ff, acc_in, step_ff, step_in;
   logic [RING_W-1:0]     k_ff, k_in;
   logic [RADIUS_W-1:0]   m_eff;
   logic [SQ_W-1:0]       r2_sum;
   logic [LHS_W-1:0]      m2_ext;

   assign m_eff  = (radius_limit < MIN_RADIUS) ? MIN_RADIUS : radius_limit;
   assign r2_sum = xx_ff + yy_ff;
   assign m2_ext = LHS_W'(m2_ff);

   // sequence squares, range check, product and search
   always_comb begin
      state_in = state_ff;
      skip_in  = skip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      xx_in    = xx_ff;
      yy_in    = yy_ff;
      r2_in    = r2_ff;
      m2_in    = m2_ff;
      rr2_in   = rr2_ff;
      lo_in    = lo_ff;
      lhs_in   = lhs_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      if (start) begin
         x_in     = point_x;
         y_in     = point_y;
         skip_in  = 1'b0;
         state_in = RS_SQX;
      end else begin
         unique case (state_ff)
            RS_SQX: begin
               xx_in    = SQ_W'(x_ff * x_ff);
               state_in = RS_SQY;
            end
            RS_SQY: begin
               yy_in    = SQ_W'(y_ff * y_ff);
               state_in = RS_SQM;
            end
            RS_SQM: begin
               m2_in    = M2_W'(m_eff * m_eff);
               rr2_in   = R2_W'(rings_used * rings_used);
               state_in = RS_CHK;
            end
            RS_CHK: begin
               r2_in   = r2_sum;
               acc_in  = m2_ext;
               step_in = m2_ext + (m2_ext << 1);
               k_in    = RING_W'(1);
               if ((r2_sum == '0) || (r2_sum > SQ_W'(m2_ff))) begin
                  skip_in  = 1'b1;
                  state_in = RS_DONE;
               end else begin
                  state_in = RS_LO;
               end
            end
            RS_LO: begin
               lo_in    = LHS_W'(r2_ff[HALF-1:0] * rr2_ff);
               state_in = RS_HI;
            end
            RS_HI: begin
               lhs_in   = (LHS_W'(r2_ff[SQ_W-1:HALF] * rr2_ff) << HALF) + lo_ff;
               state_in = RS_SRCH;
            end
            RS_SRCH: begin
               // advance k while k^2 * m^2 stays below r^2 * R^2
               if ((lhs_ff <= acc_ff) || (k_ff == rings_used)) begin
                  state_in = RS_DONE;
               end else begin
                  k_in    = k_ff + 1'b1;
                  acc_in  = acc_ff + step_ff;
                  step_in = step_ff + (m2_ext << 1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      r2_ff   <= r2_in;
      m2_ff   <= m2_in;
      rr2_ff  <= rr2_in;
      lo_ff   <= lo_in;
      lhs_ff  <= lhs_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      k_ff    <= k_in;
   end

   assign status.done = (state_ff == RS_DONE);
   assign status.skip = skip_ff;
   assign ring        = k_ff;

endmodule

// ===== rtl/core/pbin_cordic.sv =====
// Iterative CORDIC azimuth, one vectoring step per cycle, then sector scaling.
module pbin_cordic #(
   parameter int MAX_SECTORS  = 64,
   parameter int CORDIC_STEPS = 16,
   localparam int SEC_W = $clog2(MAX_SECTORS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pbin_pkg::coord_type  point_x,
   input  pbin_pkg::coord_type  point_y,
   input  logic [SEC_W-1:0]     sectors_used,
   output logic                 done,
   output logic [SEC_W-1:0]     sector
);
   import pbin_pkg::*;

   localparam int STEPS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int ITER_W = $clog2(STEPS);
   localparam int CW     = COORD_W + 20;
   localparam int PROD_W = PHASE_W + SEC_W + 1;

   localparam logic [1:0] CS_IDLE  = 2'd0;
   localparam logic [1:0] CS_ITER  = 2'd1;
   localparam logic [1:0] CS_SCALE = 2'd2;
   localparam logic [1:0] CS_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [SEC_W-1:0]        sector_ff, sector_in;
   logic signed [CW-1:0]    xs, ys, dx, dy;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W-PHASE_W-1:0] quot;

   assign xs   = CW'(point_x) <<< 16;
   assign ys   = CW'(point_y) <<< 16;
   assign dx   = y_ff >>> iter_ff;
   assign dy   = x_ff >>> iter_ff;
   assign prod = PROD_W'(phase_ff) * PROD_W'(sectors_used) + PROD_W'({PHASE_W{1'b1}});
   assign quot = prod[PROD_W-1:PHASE_W];

   // rotate toward the x axis and accumulate phase
   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      phase_in  = phase_ff;
      iter_in   = iter_ff;
      sector_in = sector_ff;
      if (start) begin
         iter_in = '0;
         if (point_y == '0) begin
            phase_in = point_x[COORD_W-1] ? HALF_TURN : '0;
            state_in = CS_SCALE;
         end else begin
            state_in = CS_ITER;
            if (point_x[COORD_W-1]) begin
               x_in     = -xs;
               y_in     = -ys;
               phase_in = HALF_TURN;
            end else begin
               x_in     = xs;
               y_in     = ys;
               phase_in = '0;
            end
         end
      end else begin
         unique case (state_ff)
            CS_ITER: begin
               if (y_ff > 0) begin
                  x_in     = x_ff + dx;
                  y_in     = y_ff - dy;
                  phase_in = phase_ff + atan_turns(5'(iter_ff));
               end else begin
                  x_in     = x_ff - dx;
                  y_in     = y_ff + dy;
                  phase_in = phase_ff - atan_turns(5'(iter_ff));
               end
               iter_in = iter_ff + 1'b1;
               if (iter_ff == ITER_W'(STEPS - 1)) begin
                  state_in = CS_SCALE;
               end
            end
            CS_SCALE: begin
               // clamp sector into one to sectors in use
               if (quot == '0) begin
                  sector_in = SEC_W'(1);
               end else if (quot > (PROD_W-PHASE_W)'(sectors_used)) begin
                  sector_in = sectors_used;
               end else begin
                  sector_in = SEC_W'(quot);
               end
               state_in = CS_DONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      phase_ff  <= phase_in;
      iter_ff   <= iter_in;
      sector_ff <= sector_in;
   end

   assign done   = (state_ff == CS_DONE);
   assign sector = sector_ff;

endmodule

// ===== rtl/core/polar_max_height_binner.sv =====
// Top level of the polar max-height binner: sequencer, cell RAM and registers.
//
//  channel | direction | handshake               | beat payload
//  req     | in        | req_valid / req_ready   | operation, point x/y/z, read ring/sector
//  rsp     | out       | rsp_valid / rsp_ready   | cell height, cell occupied
//  csr     | in        | csr_we                  | register index, write data
//
//  One item at a time. An add point runs the iterative CORDIC and the ring search
//  side by side and waits for both. A read goes through the registered RAM port.
//  A clear sweeps every cell entry, one cell entry per cycle.
//  After reset the same sweep runs before req_ready rises.
//  A pending response does not block new beats; only a read waits for the slot.
module polar_max_height_binner #(
   parameter int MAX_RINGS    = pbin_pkg::DEF_MAX_RINGS,
   parameter int MAX_SECTORS  = pbin_pkg::DEF_MAX_SECTORS,
   parameter int CORDIC_STEPS = pbin_pkg::DEF_CORDIC_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  pbin_pkg::coord_type               req_point_x,
   input  pbin_pkg::coord_type               req_point_y,
   input  pbin_pkg::coord_type               req_point_z,
   input  logic [4:0]                        req_read_ring,
   input  logic [5:0]                        req_read_sector,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pbin_pkg::height_type              rsp_cell_height,
   output logic                              rsp_cell_occupied,
   input  logic                              csr_we,
   input  logic [pbin_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbin_pkg::CSR_W-1:0]        csr_wdata
);
   import pbin_pkg::*;

   localparam int RING_W = $clog2(MAX_RINGS + 1);
   localparam int SEC_W  = $clog2(MAX_SECTORS + 1);
   localparam int CELLS  = MAX_RINGS * MAX_SECTORS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CELL_W = HEIGHT_W + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_RDREQ = 3'd5;
   localparam logic [2:0] ST_RDOUT = 3'd6;

   // registers
   logic [5:0]          ring_count_ff;
   logic [6:0]          sector_count_ff;
   logic [RADIUS_W-1:0] radius_limit_ff;
   coord_type           sensor_height_ff;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   height_type          h_ff, h_in;
   logic                low_ff, low_in;
   logic                in_range_ff, in_range_in;
   logic                rsp_valid_ff, rsp_valid_in;
   height_type          rsp_height_ff, rsp_height_in;
   logic                rsp_occ_ff, rsp_occ_in;

   logic [RING_W-1:0]   rings_used;
   logic [SEC_W-1:0]    sectors_used;
   logic                accept, start_add;
   height_type          h_sum;
   logic [ADDR_W-1:0]   read_addr, add_addr;
   unit_status_type     ring_status;
   logic [RING_W-1:0]   ring;
   logic                cordic_done;
   logic [SEC_W-1:0]    sector;
   logic                wr_en, do_update;
   logic [CELL_W-1:0]   wr_data, rd_data;
   logic                old_occ;
   height_type          old_h;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= RST_RING_COUNT;
         sector_count_ff  <= RST_SECTOR_COUNT;
         radius_limit_ff  <= RST_RADIUS_LIMIT;
         sensor_height_ff <= RST_SENSOR_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RING_COUNT:    ring_count_ff    <= csr_wdata[5:0];
            CSR_SECTOR_COUNT:  sector_count_ff  <= csr_wdata[6:0];
            CSR_RADIUS_LIMIT:  radius_limit_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_SENSOR_HEIGHT: sensor_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate grid sizes
   always_comb begin
      if (ring_count_ff == '0) begin
         rings_used = RING_W'(1);
      end else if (32'(ring_count_ff) > MAX_RINGS) begin
         rings_used = RING_W'(MAX_RINGS);
      end else begin
         rings_used = RING_W'(ring_count_ff);
      end
      if (sector_count_ff == '0) begin
         sectors_used = SEC_W'(1);
      end else if (32'(sector_count_ff) > MAX_SECTORS) begin
         sectors_used = SEC_W'(MAX_SECTORS);
      end else begin
         sectors_used = SEC_W'(sector_count_ff);
      end
   end

   assign accept    = req_valid && req_ready;
   assign start_add = accept && (req_operation == OP_ADD);
   assign h_sum     = HEIGHT_W'(req_point_z) + HEIGHT_W'(sensor_height_ff);
   assign read_addr = ADDR_W'(ADDR_W'(req_read_ring) * ADDR_W'(MAX_SECTORS))
                      + ADDR_W'(req_read_sector);
   assign add_addr  = ADDR_W'(ADDR_W'(ring - 1'b1) * ADDR_W'(MAX_SECTORS))
                      + ADDR_W'(sector - 1'b1);

   pbin_ring #(
      .MAX_RINGS (MAX_RINGS)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .start        (start_add),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .radius_limit (radius_limit_ff),
      .rings_used   (rings_used),
      .status       (ring_status),
      .ring         (ring)
   );

   pbin_cordic #(
      .MAX_SECTORS  (MAX_SECTORS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock        (clock),
      .reset        (reset),
      .start        (start_add),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .sectors_used (sectors_used),
      .done         (cordic_done),
      .sector       (sector)
   );

   assign old_occ   = rd_data[CELL_W-1];
   assign old_h     = rd_data[HEIGHT_W-1:0];
   assign do_update = !old_occ || (old_h < h_ff);
   assign wr_en     = (state_ff == ST_CLEAR) || ((state_ff == ST_UPD) && do_update);
   assign wr_data   = (state_ff == ST_CLEAR) ? '0 : {1'b1, h_ff};

   pbin_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      h_in          = h_ff;
      low_in        = low_ff;
      in_range_in   = in_range_ff;
      rsp_height_in = rsp_height_ff;
      rsp_occ_in    = rsp_occ_ff;
      // drop the response once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_ADD: begin
                     h_in     = h_sum;
                     low_in   = (h_sum <= LOW_LIMIT);
                     state_in = ST_CALC;
                  end
                  OP_READ: begin
                     in_range_in = (32'(req_read_ring) < 32'(rings_used))
                                && (32'(req_read_sector) < 32'(sectors_used));
                     addr_in     = read_addr;
                     state_in    = ST_RDREQ;
                  end
                  OP_CLEAR: begin
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CALC: begin
            if (ring_status.done && cordic_done) begin
               if (low_ff || ring_status.skip) begin
                  state_in = ST_IDLE;
               end else begin
                  addr_in  = add_addr;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK:  state_in = ST_UPD;
         ST_UPD:   state_in = ST_IDLE;
         ST_RDREQ: state_in = ST_RDOUT;
         ST_RDOUT: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_occ_in    = old_occ && in_range_ff;
               rsp_height_in = (old_occ && in_range_ff) ? old_h : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff          <= h_in;
      low_ff        <= low_in;
      in_range_ff   <= in_range_in;
      rsp_height_ff <= rsp_height_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_height   = rsp_height_ff;
   assign rsp_cell_occupied = rsp_occ_ff;

endmodule

// ===== tb/sv/tb_polar_max_height_binner.sv =====
// Testbench of the polar max-height binner: directed table, random traffic, self-checking.
`timescale 1ns / 1ps

module tb_polar_max_height_binner;
   import pbin_pkg::*;

   localparam int N_RINGS   = DEF_MAX_RINGS;
   localparam int N_SECTORS = DEF_MAX_SECTORS;
   localparam int N_STEPS   = DEF_CORDIC_STEPS;
   localparam int N_CELLS   = N_RINGS * N_SECTORS;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [1:0] op;
      coord_type  x;
      coord_type  y;
      coord_type  z;
      logic [4:0] ring;
      logic [5:0] sector;
   } bin_req_type;

   typedef struct packed {
      height_type height;
      logic       occupied;
   } cell_rsp_type;

   // directed row: request plus an optional typed-in result
   typedef struct packed {
      bin_req_type  req;
      logic         has_fixed;
      cell_rsp_type fixed;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_ADD;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_point_z = '0;
   logic [4:0] req_read_ring = '0;
   logic [5:0] req_read_sector = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   height_type rsp_cell_height;
   logic rsp_cell_occupied;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RING_COUNT;
   logic [CSR_W-1:0] csr_wdata = '0;

   polar_max_height_binner uut (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .req_point_x, .req_point_y, .req_point_z, .req_read_ring, .req_read_sector,
      .rsp_valid, .rsp_ready, .rsp_cell_height, .rsp_cell_occupied,
      .csr_we, .csr_index, .csr_wdata
   );

   // grid shadow
   logic [5:0]  ring_cfg;
   logic [6:0]  sector_cfg;
   logic [18:0] radius_cfg;
   logic signed [19:0] offset_cfg;
   height_type  cell_peak [N_CELLS];
   logic        cell_taken [N_CELLS];

   cell_rsp_type pending_cells [$];
   int           mismatches = 0;
   logic         stall_hold = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned rings_in_use();
      if (ring_cfg < 1) return 1;
      return (ring_cfg > N_RINGS) ? N_RINGS : 32'(ring_cfg);
   endfunction

   function automatic int unsigned sectors_in_use();
      if (sector_cfg < 1) return 1;
      return (sector_cfg > N_SECTORS) ? N_SECTORS : 32'(sector_cfg);
   endfunction

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   // fixed-step vectoring CORDIC, phase in 2^-32 turn
   function automatic logic [31:0] azimuth_of(longint px, longint py);
      logic [31:0] ph;
      longint dx, dy;
      longint cx, cy;
      ph = '0;
      cx = px;
      cy = py;
      if (cy == 0) return (cx < 0) ? HALF_TURN : 32'd0;
      cx = cx * 65536;
      cy = cy * 65536;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         ph = HALF_TURN;
      end
      for (int i = 0; i < N_STEPS && i < ATAN_ENTRIES; i++) begin
         dx = shift_floor(cy, i);
         dy = shift_floor(cx, i);
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            ph += atan_turns(i[4:0]);
         end else begin
            cx -= dx;
            cy += dy;
            ph -= atan_turns(i[4:0]);
         end
      end
      return ph;
   endfunction

   task automatic bin_point(coord_type px, coord_type py, coord_type pz);
      int unsigned nr, ns, ring, sector, idx;
      longint unsigned rad, r2, lhs, sec_wide;
      longint h;
      nr = rings_in_use();
      ns = sectors_in_use();
      rad = 64'((radius_cfg < MIN_RADIUS) ? MIN_RADIUS : radius_cfg);
      r2 = longint'(px) * longint'(px) + longint'(py) * longint'(py);
      h = longint'(pz) + longint'(offset_cfg);
      if (r2 == 0 || r2 > rad * rad) return;
      if (h <= longint'(LOW_LIMIT)) return;
      lhs = r2 * nr * nr;
      ring = nr;
      for (int unsigned k = 1; k <= nr; k++) begin
         if (lhs <= longint'(k) * k * rad * rad) begin
            ring = k;
            break;
         end
      end
      sec_wide = (longint'(azimuth_of(px, py)) * ns + 64'hFFFF_FFFF) >> 32;
      sector = sec_wide[31:0];
      if (sector < 1) sector = 1;
      if (sector > ns) sector = ns;
      idx = (ring - 1) * N_SECTORS + (sector - 1);
      if (!cell_taken[idx] || cell_peak[idx] < height_type'(h)) begin
         cell_peak[idx] = height_type'(h);
         cell_taken[idx] = 1'b1;
      end
   endtask

   // advance the shadow grid by one accepted beat
   task automatic apply_request(bin_req_type rq, logic has_fixed, cell_rsp_type fixed);
      cell_rsp_type c;
      int unsigned idx;
      case (rq.op)
         OP_ADD: begin
            bin_point(rq.x, rq.y, rq.z);
         end
         OP_CLEAR: begin
            foreach (cell_taken[i]) cell_taken[i] = 1'b0;
         end
         OP_READ: begin
            c = '0;
            if (rq.ring < rings_in_use() && rq.sector < sectors_in_use()) begin
               idx = rq.ring * N_SECTORS + rq.sector;
               if (cell_taken[idx]) begin
                  c.height = cell_peak[idx];
                  c.occupied = 1'b1;
               end
            end
            if (has_fixed && c != fixed) begin
               $display("%0t directed row disagrees: table %h shadow %h", $time, fixed, c);
               mismatches++;
            end
            pending_cells = {pending_cells, (has_fixed ? fixed : c)};
         end
         default: ;
      endcase
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RING_COUNT:    ring_cfg = val[5:0];
         CSR_SECTOR_COUNT:  sector_cfg = val[6:0];
         CSR_RADIUS_LIMIT:  radius_cfg = val[18:0];
         CSR_SENSOR_HEIGHT: offset_cfg = val[19:0];
         default: ;
      endcase
   endtask

   // hold valid until the beat is taken
   task automatic send_beat(bin_req_type rq, logic has_fixed, cell_rsp_type fixed);
      req_valid <= 1'b1;
      req_operation <= rq.op;
      req_point_x <= rq.x;
      req_point_y <= rq.y;
      req_point_z <= rq.z;
      req_read_ring <= rq.ring;
      req_read_sector <= rq.sector;
      do @(posedge clock); while (!req_ready);
      apply_request(rq, has_fixed, fixed);
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) != 0 || gap == 0) return;
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // wait until every result is back and the block is ready again
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0 || !req_ready) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic bin_req_type make_req(logic [1:0] op, int x, int y, int z, int r, int s);
      bin_req_type rq;
      rq.op = op;
      rq.x = 20'(x);
      rq.y = 20'(y);
      rq.z = 20'(z);
      rq.ring = 5'(r);
      rq.sector = 6'(s);
      return rq;
   endfunction

   function automatic dir_row_type row(bin_req_type rq, logic fx, int h, logic occ);
      dir_row_type d;
      d.req = rq;
      d.has_fixed = fx;
      d.fixed.height = 21'(h);
      d.fixed.occupied = occ;
      return d;
   endfunction

   // random coordinate, mostly inside the radius, sometimes full range
   function automatic int pick_coord(int span);
      if ($urandom_range(0, 7) == 0) return $signed(20'($urandom));
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic bin_req_type random_req();
      int unsigned pick, span;
      bin_req_type rq;
      span = (radius_cfg < 256) ? 256 : radius_cfg;
      pick = $urandom_range(0, 99);
      rq = make_req(OP_ADD, pick_coord(span), pick_coord(span),
                    ($urandom_range(0, 9) == 0) ? $signed(20'($urandom))
                                                : $urandom_range(0, 2000) - 1000,
                    $urandom_range(0, 31), $urandom_range(0, 63));
      if (pick < 45) rq.op = OP_ADD;
      else if (pick < 93) begin
         rq.op = OP_READ;
         if ($urandom_range(0, 3) != 0) begin
            rq.ring = 5'($urandom_range(0, rings_in_use() - 1));
            rq.sector = 6'($urandom_range(0, sectors_in_use() - 1));
         end
      end
      else if (pick < 96) rq.op = OP_CLEAR;
      else rq.op = 2'd3;
      return rq;
   endfunction

   // receiver stall pattern; the long hold-off overrides it
   always @(posedge clock) begin
      if (stall_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // compare results against the oldest expectation
   always @(posedge clock) begin
      cell_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cells.size() == 0) begin
            $display("%0t unexpected cell beat: height %0d occupied %b", $time,
                     rsp_cell_height, rsp_cell_occupied);
            mismatches++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_cell_height !== want.height) begin
               $display("%0t cell_height expected %0d actual %0d", $time,
                        want.height, rsp_cell_height);
               mismatches++;
            end
            if (rsp_cell_occupied !== want.occupied) begin
               $display("%0t cell_occupied expected %b actual %b", $time,
                        want.occupied, rsp_cell_occupied);
               mismatches++;
            end
         end
      end
   end

   initial begin
      dir_row_type rows [$];
      cell_rsp_type none;
      logic [CSR_W-1:0] sweep [4][4];
      int hold;
      none = '0;
      ring_cfg = RST_RING_COUNT;
      sector_cfg = RST_SECTOR_COUNT;
      radius_cfg = RST_RADIUS_LIMIT;
      offset_cfg = RST_SENSOR_HEIGHT;
      foreach (cell_taken[i]) begin
         cell_taken[i] = 1'b0;
         cell_peak[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, axis points, extremes, low heights, clear, unused op
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 0, 0), 1, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 31, 63), 1, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 0, 0, 500, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 256, 0, 100, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 256, 0, 300, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 0, 0), 1, 300, 1)};
      rows = {rows, row(make_req(OP_ADD, -20480, 0, 524287, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 19, 29), 1, 524287, 1)};
      rows = {rows, row(make_req(OP_ADD, 0, 20480, -524288, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 0, -20480, -200000, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 20481, 0, 7, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, -524288, -524288, 7, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 524287, 524287, 7, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 1000, 1000, -256000, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, 1000, -1000, 55, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_ADD, -1000, 1000, 66, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(2'd3, 5, 5, 5, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 20, 0), 1, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 0, 60), 1, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 4, 52), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 4, 37), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 4, 22), 0, 0, 0)};
      rows = {rows, row(make_req(OP_CLEAR, 0, 0, 0, 0, 0), 0, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 0, 0), 1, 0, 0)};
      rows = {rows, row(make_req(OP_READ, 0, 0, 0, 19, 29), 1, 0, 0)};
      foreach (rows[i]) send_beat(rows[i].req, rows[i].has_fixed, rows[i].fixed);
      wait_idle();

      // register sweeps: ring, sector, radius, height offset; extremes included
      sweep = '{'{20'd1, 20'd1, 20'd256, 20'h80000},
                '{20'd32, 20'd64, 20'h7FFFF, 20'h7FFFF},
                '{20'd0, 20'd127, 20'd100, 20'd0},
                '{20'd63, 20'd0, 20'd4000, 20'hFFF00}};
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_RING_COUNT, sweep[ph][0]);
         write_reg(CSR_SECTOR_COUNT, sweep[ph][1]);
         write_reg(CSR_RADIUS_LIMIT, sweep[ph][2]);
         write_reg(CSR_SENSOR_HEIGHT, sweep[ph][3]);
         if (ph == 1) begin
            // long receiver hold-off while beats keep coming
            stall_hold <= 1'b1;
            fork
               begin
                  hold = 0;
                  while (hold < 400) begin
                     @(posedge clock);
                     hold++;
                  end
                  stall_hold <= 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
            send_beat(random_req(), 1'b0, none);
            pause_sender();
         end
         wait_idle();
      end

      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
